FILE: sv/pfe_pkg.sv
// ----------------------------------------------------------------------------
// pfe_pkg: shared definitions for the postfix expression evaluator
// Character codes, status codes, widths and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package pfe_pkg;

    localparam int SYM_W           = 8;
    localparam int VALUE_W         = 32;
    localparam int STATUS_W        = 2;
    localparam int TDATA_W         = 40;
    localparam int STACK_DEPTH_DEF = 16;

    localparam logic [SYM_W-1:0] SYM_ADD  = 8'h2B;
    localparam logic [SYM_W-1:0] SYM_SUB  = 8'h2D;
    localparam logic [SYM_W-1:0] SYM_MUL  = 8'h2A;
    localparam logic [SYM_W-1:0] SYM_DIV  = 8'h2F;
    localparam logic [SYM_W-1:0] SYM_ZERO = 8'h30;

    localparam logic [VALUE_W-1:0] EMPTY_VALUE = '1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_UNDER   = 2'd1,
        ST_OVER    = 2'd2,
        ST_DIVZERO = 2'd3
    } status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;     // latch the incoming word
        logic pop;        // pop one entry (read issued to the stack RAM)
        logic cap_right;  // capture the first popped value
        logic cap_left;   // capture the second popped value
        logic exec;       // compute add/sub/mul, or start the divide
        logic cap_div;    // capture the quotient
        logic push;       // push operand or result
        logic top;        // read the top of the stack
        logic finish;     // load the output register and empty the stack
    } pfe_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_is_op;   // incoming word is an operator
        logic is_div;     // latched word is a divide
        logic div_zero;   // right operand is zero
        logic last;       // latched word ends the expression
        logic div_done;   // quotient is ready
        logic out_free;   // output register can take a result this cycle
    } pfe_stat_t;

    function automatic logic is_operator(input logic [SYM_W-1:0] sym);
        return (sym == SYM_ADD) || (sym == SYM_SUB) || (sym == SYM_MUL) || (sym == SYM_DIV);
    endfunction

endpackage

FILE: sv/pfe_ram.sv
// ----------------------------------------------------------------------------
// pfe_ram: generic single-clock RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module pfe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/pfe_div.sv
// ----------------------------------------------------------------------------
// pfe_div: iterative signed divider
// Restoring division on magnitudes, one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
module pfe_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [pfe_pkg::VALUE_W-1:0] dividend,
    input  logic [pfe_pkg::VALUE_W-1:0] divisor,
    output logic                       done,
    output logic [pfe_pkg::VALUE_W-1:0] quotient
);

    localparam int W     = pfe_pkg::VALUE_W;
    localparam int CNT_W = $clog2(W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [W-1:0]     rem_reg, rem_next;
    logic [W-1:0]     quo_reg, quo_next;
    logic [W-1:0]     den_reg, den_next;
    logic             neg_reg, neg_next;

    logic [W:0]       trial;
    logic [W-1:0]     diff;
    logic             ge;

    // The partial remainder stays below the divisor, so W bits hold the difference.
    assign trial = {rem_reg, quo_reg[W-1]};
    assign diff  = trial[W-1:0] - den_reg;
    assign ge    = trial >= {1'b0, den_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend[W-1] ? (~dividend + W'(1)) : dividend;
            den_next  = divisor[W-1] ? (~divisor + W'(1)) : divisor;
            neg_next  = dividend[W-1] ^ divisor[W-1];
        end else if (busy_reg) begin
            rem_next = ge ? diff : trial[W-1:0];
            quo_next = {quo_reg[W-2:0], ge};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    // Negation of the magnitude wraps the most negative quotient onto itself.
    assign done     = done_reg;
    assign quotient = neg_reg ? (~quo_reg + W'(1)) : quo_reg;

endmodule

FILE: sv/pfe_dpath.sv
// ----------------------------------------------------------------------------
// pfe_dpath: evaluator datapath
// Stack RAM and pointer, operand registers, ALU, divider, error and output.
// ----------------------------------------------------------------------------
module pfe_dpath #(
    parameter int STACK_DEPTH = pfe_pkg::STACK_DEPTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  pfe_pkg::pfe_cmd_t           cmd,
    output pfe_pkg::pfe_stat_t          stat,
    input  logic [pfe_pkg::SYM_W-1:0]   s_tdata,
    input  logic                        s_tlast,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [pfe_pkg::TDATA_W-1:0] m_tdata
);

    localparam int W      = pfe_pkg::VALUE_W;
    localparam int SW     = pfe_pkg::SYM_W;
    localparam int ADDR_W = $clog2(STACK_DEPTH);
    localparam int SP_W   = $clog2(STACK_DEPTH + 1);
    localparam int PAD_W  = pfe_pkg::TDATA_W - W - pfe_pkg::STATUS_W;

    logic [SW-1:0]        sym_reg;
    logic                 last_reg;
    logic [SP_W-1:0]      sp_reg, sp_next;
    pfe_pkg::status_t     err_reg, err_next;
    logic                 empty_reg;
    logic [W-1:0]         right_reg;
    logic [W-1:0]         left_reg;
    logic [W-1:0]         result_reg;
    logic                 out_valid_reg;
    logic [W-1:0]         out_value_reg;
    pfe_pkg::status_t     out_status_reg;

    logic [SP_W-1:0]      sp_m1;
    logic                 sp_empty;
    logic                 sp_full;
    logic                 is_op;
    logic                 is_div;
    logic                 div_zero;
    logic [W-1:0]         sym_value;
    logic [W-1:0]         push_value;
    logic [W-1:0]         alu_value;
    logic [W-1:0]         rdata;
    logic                 ram_we;
    logic                 ram_re;
    logic                 div_start;
    logic                 div_done;
    logic [W-1:0]         div_quo;
    logic                 note_valid;
    pfe_pkg::status_t     note_code;

    assign sp_m1    = sp_reg - SP_W'(1);
    assign sp_empty = (sp_reg == '0);
    assign sp_full  = (sp_reg == SP_W'(STACK_DEPTH));
    assign is_op    = pfe_pkg::is_operator(sym_reg);
    assign is_div   = (sym_reg == pfe_pkg::SYM_DIV);
    assign div_zero = (right_reg == '0);

    // Operand characters are taken as unsigned codes offset by the zero digit.
    assign sym_value  = {{(W - SW){1'b0}}, sym_reg} - W'(pfe_pkg::SYM_ZERO);
    assign push_value = is_op ? result_reg : sym_value;

    always_comb begin
        case (sym_reg)
            pfe_pkg::SYM_ADD: alu_value = left_reg + right_reg;
            pfe_pkg::SYM_SUB: alu_value = left_reg - right_reg;
            pfe_pkg::SYM_MUL: alu_value = left_reg * right_reg;
            default:          alu_value = '0;
        endcase
    end

    assign ram_we    = cmd.push && !sp_full;
    assign ram_re    = (cmd.pop || cmd.top) && !sp_empty;
    assign div_start = cmd.exec && is_div && !div_zero;

    pfe_ram #(
        .WIDTH (W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (sp_reg[ADDR_W-1:0]),
        .wdata (push_value),
        .re    (ram_re),
        .raddr (sp_m1[ADDR_W-1:0]),
        .rdata (rdata)
    );

    pfe_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (left_reg),
        .divisor  (right_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    // At most one error source is active in any cycle; the first one sticks.
    always_comb begin
        note_valid = 1'b0;
        note_code  = pfe_pkg::ST_OK;
        if ((cmd.pop || cmd.top) && sp_empty) begin
            note_valid = 1'b1;
            note_code  = pfe_pkg::ST_UNDER;
        end else if (cmd.exec && is_div && div_zero) begin
            note_valid = 1'b1;
            note_code  = pfe_pkg::ST_DIVZERO;
        end else if (cmd.push && sp_full) begin
            note_valid = 1'b1;
            note_code  = pfe_pkg::ST_OVER;
        end
    end

    always_comb begin
        err_next = err_reg;
        if (cmd.finish) begin
            err_next = pfe_pkg::ST_OK;
        end else if (note_valid && err_reg == pfe_pkg::ST_OK) begin
            err_next = note_code;
        end
    end

    always_comb begin
        sp_next = sp_reg;
        if (cmd.finish) begin
            sp_next = '0;
        end else if (cmd.pop && !sp_empty) begin
            sp_next = sp_m1;
        end else if (ram_we) begin
            sp_next = sp_reg + SP_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sp_reg        <= '0;
            err_reg       <= pfe_pkg::ST_OK;
            out_valid_reg <= 1'b0;
        end else begin
            sp_reg  <= sp_next;
            err_reg <= err_next;
            if (cmd.finish) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
        if (cmd.accept) begin
            sym_reg  <= s_tdata;
            last_reg <= s_tlast;
        end
        if (cmd.pop || cmd.top) begin
            empty_reg <= sp_empty;
        end
        if (cmd.cap_right) begin
            right_reg <= empty_reg ? pfe_pkg::EMPTY_VALUE : rdata;
        end
        if (cmd.cap_left) begin
            left_reg <= empty_reg ? pfe_pkg::EMPTY_VALUE : rdata;
        end
        if (cmd.exec) begin
            result_reg <= alu_value;
        end else if (cmd.cap_div) begin
            result_reg <= div_quo;
        end
        if (cmd.finish) begin
            out_value_reg  <= empty_reg ? pfe_pkg::EMPTY_VALUE : rdata;
            out_status_reg <= err_reg;
        end
    end

    assign stat.in_is_op = pfe_pkg::is_operator(s_tdata);
    assign stat.is_div   = is_div;
    assign stat.div_zero = div_zero;
    assign stat.last     = last_reg;
    assign stat.div_done = div_done;
    assign stat.out_free = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_status_reg, out_value_reg};

    sp_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        sp_reg <= SP_W'(STACK_DEPTH))
        else $error("stack pointer beyond stack depth");

    error_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (err_reg != pfe_pkg::ST_OK) && !cmd.finish |=> $stable(err_reg))
        else $error("recorded error replaced before the end of the expression");

    underflow_noted: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.cap_right && empty_reg |-> err_reg != pfe_pkg::ST_OK)
        else $error("pop from an empty stack left no error");

    push_full_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.push && sp_full && !cmd.finish |=> sp_reg == $past(sp_reg))
        else $error("push onto a full stack moved the stack pointer");

endmodule

FILE: sv/pfe_ctrl.sv
// ----------------------------------------------------------------------------
// pfe_ctrl: evaluator sequencer
// Steps each word through pops, execute, push and the end-of-expression read.
// ----------------------------------------------------------------------------
module pfe_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  pfe_pkg::pfe_stat_t stat,
    output pfe_pkg::pfe_cmd_t  cmd
);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_POP1   = 9'b000000010,
        S_POP2   = 9'b000000100,
        S_POP3   = 9'b000001000,
        S_EXEC   = 9'b000010000,
        S_DIVW   = 9'b000100000,
        S_PUSH   = 9'b001000000,
        S_TOP    = 9'b010000000,
        S_FINISH = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = stat.in_is_op ? S_POP1 : S_PUSH;
                end
            end
            S_POP1: begin
                cmd.pop    = 1'b1;
                state_next = S_POP2;
            end
            S_POP2: begin
                cmd.pop       = 1'b1;
                cmd.cap_right = 1'b1;
                state_next    = S_POP3;
            end
            S_POP3: begin
                cmd.cap_left = 1'b1;
                state_next   = S_EXEC;
            end
            S_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = (stat.is_div && !stat.div_zero) ? S_DIVW : S_PUSH;
            end
            S_DIVW: begin
                if (stat.div_done) begin
                    cmd.cap_div = 1'b1;
                    state_next  = S_PUSH;
                end
            end
            S_PUSH: begin
                cmd.push   = 1'b1;
                state_next = stat.last ? S_TOP : S_IDLE;
            end
            S_TOP: begin
                cmd.top    = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH: begin
                // Hold here while the previous result still waits to be taken.
                if (stat.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    div_wait_only_for_div: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DIVW |-> stat.is_div && !stat.div_zero)
        else $error("waiting on the divider for a word that is not a divide");

    push_after_operand: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.accept && !stat.in_is_op |=> state_reg == S_PUSH)
        else $error("operand word did not go straight to the push");

    finish_after_top: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> $past(cmd.top) || $past(state_reg) == S_FINISH)
        else $error("result loaded without a top-of-stack read");

endmodule

FILE: sv/postfix_expression_evaluator_unit.sv
// Sequence: an operand word is accepted and pushed; + - * pop two entries, execute and
// push; / also waits on the one-bit-per-cycle divider unless the divisor is zero. A
// final word adds the top read and the finish step, held while the last result is
// untaken; m_tvalid rises the cycle after. Only one word is in flight at a time.
// Reset (aresetn low, synchronous) empties the stack and clears the error and
// output valid; the stack RAM contents are not cleared.
// ----------------------------------------------------------------------------
// postfix_expression_evaluator_unit: postfix expression evaluator
// Evaluates a postfix character stream on a bounded operand stack and reports
// the top value and the first error at the end of each expression.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator_unit #(
    parameter int STACK_DEPTH = pfe_pkg::STACK_DEPTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [pfe_pkg::SYM_W-1:0]   s_tdata,   // [7:0] symbol
    input  logic                        s_tlast,   // last_symbol
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [pfe_pkg::TDATA_W-1:0] m_tdata    // [31:0] value, [33:32] status
);

    pfe_pkg::pfe_cmd_t  cmd;
    pfe_pkg::pfe_stat_t stat;

    pfe_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pfe_dpath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for postfix_expression_evaluator_unit
// Streams postfix expressions, one character per word, into the evaluator,
// predicts the top value and first error of each expression on its own
// operand stack, and checks every result word against that prediction.
// ----------------------------------------------------------------------------
module testbench;

    localparam int DEPTH        = pfe_pkg::STACK_DEPTH_DEF;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 80;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int SW           = pfe_pkg::SYM_W;
    localparam int VW           = pfe_pkg::VALUE_W;
    localparam int STW          = pfe_pkg::STATUS_W;

    typedef struct packed {
        logic [SW-1:0] symbol;
        logic          last;
    } symbol_word_t;

    typedef struct packed {
        logic [VW-1:0]    value;
        pfe_pkg::status_t status;
    } answer_t;

    logic                        aclk     = 1'b0;
    logic                        aresetn  = 1'b0;
    logic                        s_tvalid = 1'b0;
    logic                        s_tready;
    logic [SW-1:0]               s_tdata  = '0;
    logic                        s_tlast  = 1'b0;
    logic                        m_tvalid;
    logic                        m_tready = 1'b0;
    logic [pfe_pkg::TDATA_W-1:0] m_tdata;

    symbol_word_t pending_symbols[$];
    answer_t      expected_answers[$];
    symbol_word_t next_word;
    answer_t      want;

    // Predicted evaluator state.
    logic [VW-1:0]      operands[DEPTH];
    int                 depth_now   = 0;
    pfe_pkg::status_t   first_fault = pfe_pkg::ST_OK;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_request   = 0;
    int hold_served    = 0;
    int hold_left      = 0;
    int mismatch_count = 0;
    int cycle_count    = 0;
    int symbols_queued = 0;

    postfix_expression_evaluator_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [7:0] symbol
        .s_tlast  (s_tlast),   // last_symbol
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)    // [31:0] value, [33:32] status
    );

    always #5 aclk = ~aclk;

    function automatic logic is_op_char(input logic [SW-1:0] sym);
        return sym == pfe_pkg::SYM_ADD || sym == pfe_pkg::SYM_SUB ||
               sym == pfe_pkg::SYM_MUL || sym == pfe_pkg::SYM_DIV;
    endfunction

    function automatic void note_fault(input pfe_pkg::status_t code);
        if (first_fault == pfe_pkg::ST_OK) begin
            first_fault = code;
        end
    endfunction

    function automatic logic [VW-1:0] pop_operand();
        if (depth_now == 0) begin
            note_fault(pfe_pkg::ST_UNDER);
            return pfe_pkg::EMPTY_VALUE;
        end
        depth_now--;
        return operands[depth_now];
    endfunction

    function automatic void push_operand(input logic [VW-1:0] v);
        if (depth_now >= DEPTH) begin
            note_fault(pfe_pkg::ST_OVER);
        end else begin
            operands[depth_now] = v;
            depth_now++;
        end
    endfunction

    // Applies one accepted word to the predicted stack and queues the answer
    // that a final word produces.
    function automatic void eval_symbol(input logic [SW-1:0] sym, input logic last_sym);
        logic [VW-1:0] rhs;
        logic [VW-1:0] lhs;
        logic [VW-1:0] res;
        longint        quot;
        answer_t       ans;
        if (is_op_char(sym)) begin
            rhs = pop_operand();
            lhs = pop_operand();
            case (sym)
                pfe_pkg::SYM_ADD: res = lhs + rhs;
                pfe_pkg::SYM_SUB: res = lhs - rhs;
                pfe_pkg::SYM_MUL: res = lhs * rhs;
                default: begin
                    if (rhs == '0) begin
                        note_fault(pfe_pkg::ST_DIVZERO);
                        res = '0;
                    end else begin
                        // 64-bit quotient so that the most negative value over -1 wraps.
                        quot = longint'($signed(lhs)) / longint'($signed(rhs));
                        res  = quot[VW-1:0];
                    end
                end
            endcase
            push_operand(res);
        end else begin
            push_operand(VW'(sym) - VW'(pfe_pkg::SYM_ZERO));
        end
        if (last_sym) begin
            if (depth_now == 0) begin
                note_fault(pfe_pkg::ST_UNDER);
                ans.value = pfe_pkg::EMPTY_VALUE;
            end else begin
                ans.value = operands[depth_now - 1];
            end
            ans.status = first_fault;
            expected_answers.push_back(ans);
            depth_now   = 0;
            first_fault = pfe_pkg::ST_OK;
        end
    endfunction

    task automatic queue_symbol(input logic [SW-1:0] sym, input logic last_sym);
        symbol_word_t w;
        w.symbol = sym;
        w.last   = last_sym;
        pending_symbols.push_back(w);
        symbols_queued++;
    endtask

    function automatic logic [SW-1:0] random_op();
        case ($urandom_range(3))
            0:       return pfe_pkg::SYM_ADD;
            1:       return pfe_pkg::SYM_SUB;
            2:       return pfe_pkg::SYM_MUL;
            default: return pfe_pkg::SYM_DIV;
        endcase
    endfunction

    function automatic logic [SW-1:0] random_operand();
        logic [SW-1:0] sym;
        if ($urandom_range(99) < 85) begin
            return SW'($urandom_range(8'h30, 8'h39));
        end
        do begin
            sym = SW'($urandom_range(255));
        end while (is_op_char(sym));
        return sym;
    endfunction

    // Builds the most negative value as 128^4 * 8, then divides it by 0 - 1.
    task automatic queue_min_over_minus_one();
        int i;
        queue_symbol(8'hB0, 1'b0);
        for (i = 0; i < 3; i++) begin
            queue_symbol(8'hB0, 1'b0);
            queue_symbol(pfe_pkg::SYM_MUL, 1'b0);
        end
        queue_symbol("8", 1'b0);
        queue_symbol(pfe_pkg::SYM_MUL, 1'b0);
        queue_symbol("0", 1'b0);
        queue_symbol("1", 1'b0);
        queue_symbol(pfe_pkg::SYM_SUB, 1'b0);
        queue_symbol(pfe_pkg::SYM_DIV, 1'b1);
    endtask

    // A well-formed expression with random content; the long ones may run
    // past the stack depth.
    task automatic queue_expression();
        logic [SW-1:0] chars[$];
        int            len;
        int            depth;
        int            i;
        len   = ($urandom_range(9) == 0) ? $urandom_range(14, 24) : $urandom_range(1, 9);
        depth = 0;
        for (i = 0; i < len; i++) begin
            if (depth >= 2 && $urandom_range(2) == 0) begin
                chars.push_back(random_op());
                depth--;
            end else begin
                chars.push_back(random_operand());
                depth++;
            end
        end
        while (depth > 1) begin
            chars.push_back(random_op());
            depth--;
        end
        foreach (chars[k]) begin
            queue_symbol(chars[k], k == chars.size() - 1);
        end
    endtask

    task automatic queue_random(input int count);
        int goal;
        int pick;
        goal = symbols_queued + count;
        while (symbols_queued < goal) begin
            pick = $urandom_range(99);
            if (pick < 12) begin
                queue_symbol(SW'($urandom_range(255)), $urandom_range(7) == 0);
            end else if (pick < 15) begin
                queue_min_over_minus_one();
            end else begin
                queue_expression();
            end
        end
    endtask

    task automatic wait_idle();
        while (pending_symbols.size() != 0 || s_tvalid || expected_answers.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // Input side: offers queued words, idling between them at random.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                eval_symbol(s_tdata, s_tlast);
            end
            if (!s_tvalid || s_tready) begin
                if (pending_symbols.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_word = pending_symbols.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= next_word.symbol;
                    s_tlast  <= next_word.last;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result side back-pressure, including one long hold-off on request.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_request != hold_served) begin
            m_tready    <= 1'b0;
            hold_left   <= HOLD_CYCLES;
            hold_served <= hold_request;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_answers.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("%0t: unexpected result word value=%0d status=%0d", $realtime,
                             $signed(m_tdata[VW-1:0]), m_tdata[VW +: STW]);
                end
            end else begin
                want = expected_answers.pop_front();
                if (m_tdata[VW-1:0] !== want.value ||
                    m_tdata[VW +: STW] !== want.status) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("%0t: result mismatch: value exp %0d got %0d, status exp %0d got %0d",
                                 $realtime, $signed(want.value),
                                 $signed(m_tdata[VW-1:0]), want.status,
                                 m_tdata[VW +: STW]);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        int i;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: pop from an empty stack, overflow with extreme symbols and
        // every operator, then a divide by zero.
        queue_symbol(pfe_pkg::SYM_ADD, 1'b1);
        for (i = 0; i < DEPTH + 1; i++) begin
            if (i == 0) begin
                queue_symbol(8'h00, 1'b0);
            end else if (i == 1) begin
                queue_symbol(8'hFF, 1'b0);
            end else begin
                queue_symbol(8'h30 + SW'(i % 10), 1'b0);
            end
        end
        queue_symbol(pfe_pkg::SYM_ADD, 1'b0);
        queue_symbol(pfe_pkg::SYM_SUB, 1'b0);
        queue_symbol(pfe_pkg::SYM_MUL, 1'b0);
        queue_symbol(pfe_pkg::SYM_DIV, 1'b1);
        queue_symbol("5", 1'b0);
        queue_symbol("0", 1'b0);
        queue_symbol(pfe_pkg::SYM_DIV, 1'b1);
        queue_min_over_minus_one();

        // No idling on either side.
        queue_random(100);
        wait_idle();

        send_idle_pct  = 79;
        recv_stall_pct = 0;
        queue_random(100);
        wait_idle();

        send_idle_pct  = 0;
        recv_stall_pct = 79;
        queue_random(100);
        wait_idle();

        send_idle_pct  = 29;
        recv_stall_pct = 29;
        queue_random(100);
        wait_idle();

        // Long receiver hold-off while the sender keeps offering words.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = hold_request + 1;
        queue_random(80);
        wait_idle();

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

FILE: sim.f
sv/pfe_pkg.sv
sv/pfe_ram.sv
sv/pfe_div.sv
sv/pfe_dpath.sv
sv/pfe_ctrl.sv
sv/postfix_expression_evaluator_unit.sv
tb/testbench.sv
